[sv/ffrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared types, character codes and result kinds for the FASTA/FASTQ record
// parser and its port checker.
// ----------------------------------------------------------------------------
package ffrp_pkg;

	typedef enum logic [2:0] {
		MODE_SEEK    = 3'd0,
		MODE_FA_NAME = 3'd1,
		MODE_FA_SEQ  = 3'd2,
		MODE_FQ_NAME = 3'd3,
		MODE_FQ_SEQ  = 3'd4,
		MODE_FQ_PLUS = 3'd5,
		MODE_FQ_QUAL = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NAME = 2'd0,
		KIND_SEQ  = 2'd1,
		KIND_QUAL = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AT    = 8'h40;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic       ok;
		logic       fastq;
	} result_t;

	// Whitespace other than newline.
	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

[sv/fasta_fastq_record_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser_core
// Byte-at-a-time FASTA/FASTQ parser: emits tagged name, sequence and quality
// characters and one record-end request per record.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_ready   | byte_value[7:0], end_of_input
// out     | out_valid/out_ready | out_kind[1:0], out_char[7:0], record_ok,
//         |                     | record_is_fastq
//
// One byte per cycle is sustained while the output is not stalled; a request
// enters the input register, the mode update and result decode run from that
// register, and a result is registered in the output register.
// Reset clears the parse mode to seeking and empties both registers.
// A stalled output holds its result; the input register keeps taking
// requests only while its contents can move on.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_char,
	output logic       record_ok,
	output logic       record_is_fastq
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eoi_s1;
	ffrp_pkg::mode_t      mode_q;
	ffrp_pkg::mode_t      mode_next;
	logic                 res_valid;
	ffrp_pkg::result_t    res;
	ffrp_pkg::result_t    out_q;
	logic                 out_valid_q;
	logic                 go_s1;
	logic                 fq;
	logic                 line_end;

	assign go_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			eoi_s1  <= end_of_input;
		end
	end

	assign fq = (mode_q == ffrp_pkg::MODE_FQ_NAME) || (mode_q == ffrp_pkg::MODE_FQ_SEQ) ||
		(mode_q == ffrp_pkg::MODE_FQ_PLUS) || (mode_q == ffrp_pkg::MODE_FQ_QUAL);
	assign line_end = (byte_s1 == ffrp_pkg::CH_LF) || (byte_s1 == ffrp_pkg::CH_NUL);

	always_comb begin
		mode_next = mode_q;
		res_valid = 1'b0;
		res.kind  = ffrp_pkg::KIND_NAME;
		res.ch    = byte_s1;
		res.ok    = 1'b0;
		res.fastq = fq;
		if (eoi_s1 && mode_q != ffrp_pkg::MODE_SEEK) begin
			mode_next = ffrp_pkg::MODE_SEEK;
			res_valid = 1'b1;
			res.kind  = ffrp_pkg::KIND_END;
			res.ch    = ffrp_pkg::CH_NUL;
			res.ok    = (mode_q == ffrp_pkg::MODE_FA_SEQ);
		end else begin
			case (mode_q)
				ffrp_pkg::MODE_FA_NAME, ffrp_pkg::MODE_FQ_NAME: begin
					if (line_end) begin
						mode_next = (mode_q == ffrp_pkg::MODE_FA_NAME) ?
							ffrp_pkg::MODE_FA_SEQ : ffrp_pkg::MODE_FQ_SEQ;
					end else if (byte_s1 != ffrp_pkg::CH_CR) begin
						res_valid = 1'b1;
					end
				end
				ffrp_pkg::MODE_FA_SEQ: begin
					res.kind = ffrp_pkg::KIND_SEQ;
					if (byte_s1 == ffrp_pkg::CH_GT || byte_s1 == ffrp_pkg::CH_NUL) begin
						// A '>' closes this record and opens the next one.
						mode_next = (byte_s1 == ffrp_pkg::CH_GT) ?
							ffrp_pkg::MODE_FA_NAME : ffrp_pkg::MODE_SEEK;
						res_valid = 1'b1;
						res.kind  = ffrp_pkg::KIND_END;
						res.ch    = ffrp_pkg::CH_NUL;
						res.ok    = 1'b1;
					end else if (byte_s1 != ffrp_pkg::CH_LF &&
						!ffrp_pkg::is_blank(byte_s1)) begin
						res_valid = 1'b1;
					end
				end
				ffrp_pkg::MODE_FQ_SEQ: begin
					res.kind = ffrp_pkg::KIND_SEQ;
					if (line_end) begin
						mode_next = ffrp_pkg::MODE_FQ_PLUS;
					end else if (!ffrp_pkg::is_blank(byte_s1)) begin
						res_valid = 1'b1;
					end
				end
				ffrp_pkg::MODE_FQ_PLUS: begin
					if (line_end) begin
						mode_next = ffrp_pkg::MODE_FQ_QUAL;
					end
				end
				ffrp_pkg::MODE_FQ_QUAL: begin
					res.kind = ffrp_pkg::KIND_QUAL;
					if (line_end) begin
						mode_next = ffrp_pkg::MODE_SEEK;
						res_valid = 1'b1;
						res.kind  = ffrp_pkg::KIND_END;
						res.ch    = ffrp_pkg::CH_NUL;
						res.ok    = 1'b1;
					end else if (!ffrp_pkg::is_blank(byte_s1)) begin
						res_valid = 1'b1;
					end
				end
				default: begin
					// Seeking, including the unused mode code.
					mode_next = ffrp_pkg::MODE_SEEK;
					if (!eoi_s1 && byte_s1 == ffrp_pkg::CH_GT) begin
						mode_next = ffrp_pkg::MODE_FA_NAME;
					end else if (!eoi_s1 && byte_s1 == ffrp_pkg::CH_AT) begin
						mode_next = ffrp_pkg::MODE_FQ_NAME;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ffrp_pkg::MODE_SEEK;
			out_valid_q <= 1'b0;
		end else begin
			if (go_s1) begin
				mode_q <= mode_next;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= go_s1 && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_kind        = out_q.kind;
	assign out_char        = out_q.ch;
	assign record_ok       = out_q.ok;
	assign record_is_fastq = out_q.fastq;

endmodule

[sv/ffrp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrp_checker
// Port-level checks for the FASTA/FASTQ record parser, bound to the top level.
// ----------------------------------------------------------------------------
module ffrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_char,
	input logic       record_ok,
	input logic       record_is_fastq
);

	// Only a record end may report a complete record.
	a_ok_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != ffrp_pkg::KIND_END |-> !record_ok)
		else $error("record_ok set on a character request");

	// A record end carries no character.
	a_end_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == ffrp_pkg::KIND_END |-> out_char == ffrp_pkg::CH_NUL)
		else $error("record end with non-zero character");

	// Quality characters only exist in FASTQ records.
	a_qual_is_fastq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == ffrp_pkg::KIND_QUAL |-> record_is_fastq)
		else $error("quality character outside a FASTQ record");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char)
			&& $stable(record_ok) && $stable(record_is_fastq))
		else $error("output request changed while stalled");

endmodule

bind fasta_fastq_record_parser_core ffrp_checker u_ffrp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.out_kind        (out_kind),
	.out_char        (out_char),
	.record_ok       (record_ok),
	.record_is_fastq (record_is_fastq)
);

[test/fasta_fastq_record_parser_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser_core_test
// Self-checking bench for the FASTA/FASTQ record parser. Byte streams of short
// well-formed, truncated and malformed records are pushed through the input
// channel. A bit-accurate parser model predicts every tagged character and
// record end, and each output request is checked against it in order.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser_core_test;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_value = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_char;
	logic       record_ok;
	logic       record_is_fastq;

	byte_req_t         pending_reqs[$];
	ffrp_pkg::result_t expected_tokens[$];
	ffrp_pkg::mode_t   parser_mode = ffrp_pkg::MODE_SEEK;

	byte_req_t         next_req;
	ffrp_pkg::result_t predicted;
	ffrp_pkg::result_t wanted;
	ffrp_pkg::mode_t   next_mode;
	logic      in_fire = 1'b0;
	logic      long_hold = 1'b0;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        total_items = 0;
	int        accepted_count = 0;
	int        result_count = 0;
	int        error_count = 0;
	int        kind_seen[4] = '{0, 0, 0, 0};
	int        truncated_ends = 0;

	fasta_fastq_record_parser_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.byte_value      (byte_value),
		.end_of_input    (end_of_input),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_kind        (out_kind),
		.out_char        (out_char),
		.record_ok       (record_ok),
		.record_is_fastq (record_is_fastq)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One parser step: the result that a byte causes, if any, and the mode after it.
	function automatic logic parse_step(input logic [7:0] c, input logic eoi,
			input ffrp_pkg::mode_t mode, output ffrp_pkg::mode_t after,
			output ffrp_pkg::result_t res);
		logic fastq;
		logic line_end;
		logic blank;
		fastq = (mode == ffrp_pkg::MODE_FQ_NAME) || (mode == ffrp_pkg::MODE_FQ_SEQ) ||
			(mode == ffrp_pkg::MODE_FQ_PLUS) || (mode == ffrp_pkg::MODE_FQ_QUAL);
		line_end = (c == ffrp_pkg::CH_LF) || (c == ffrp_pkg::CH_NUL);
		blank = (c == ffrp_pkg::CH_SPACE) || (c == ffrp_pkg::CH_TAB) ||
			(c == ffrp_pkg::CH_VT) || (c == ffrp_pkg::CH_FF) || (c == ffrp_pkg::CH_CR);
		res = '{ffrp_pkg::KIND_NAME, c, 1'b0, fastq};
		after = mode;
		parse_step = 1'b1;
		if (mode == ffrp_pkg::MODE_SEEK) begin
			parse_step = 1'b0;
			if (!eoi && c == ffrp_pkg::CH_GT)
				after = ffrp_pkg::MODE_FA_NAME;
			else if (!eoi && c == ffrp_pkg::CH_AT)
				after = ffrp_pkg::MODE_FQ_NAME;
		end else if (eoi) begin
			res = '{ffrp_pkg::KIND_END, ffrp_pkg::CH_NUL,
				mode == ffrp_pkg::MODE_FA_SEQ, fastq};
			after = ffrp_pkg::MODE_SEEK;
		end else begin
			case (mode)
				ffrp_pkg::MODE_FA_NAME, ffrp_pkg::MODE_FQ_NAME: begin
					if (line_end) begin
						parse_step = 1'b0;
						after = (mode == ffrp_pkg::MODE_FA_NAME) ?
							ffrp_pkg::MODE_FA_SEQ : ffrp_pkg::MODE_FQ_SEQ;
					end else if (c == ffrp_pkg::CH_CR) begin
						parse_step = 1'b0;
					end
				end
				ffrp_pkg::MODE_FA_SEQ: begin
					// A '>' closes this record and opens the next one at once.
					if (c == ffrp_pkg::CH_GT || c == ffrp_pkg::CH_NUL) begin
						res = '{ffrp_pkg::KIND_END, ffrp_pkg::CH_NUL, 1'b1, 1'b0};
						after = (c == ffrp_pkg::CH_GT) ?
							ffrp_pkg::MODE_FA_NAME : ffrp_pkg::MODE_SEEK;
					end else if (c == ffrp_pkg::CH_LF || blank) begin
						parse_step = 1'b0;
					end else begin
						res.kind = ffrp_pkg::KIND_SEQ;
					end
				end
				ffrp_pkg::MODE_FQ_SEQ: begin
					if (line_end) begin
						parse_step = 1'b0;
						after = ffrp_pkg::MODE_FQ_PLUS;
					end else if (blank) begin
						parse_step = 1'b0;
					end else begin
						res.kind = ffrp_pkg::KIND_SEQ;
					end
				end
				ffrp_pkg::MODE_FQ_PLUS: begin
					parse_step = 1'b0;
					if (line_end)
						after = ffrp_pkg::MODE_FQ_QUAL;
				end
				default: begin
					if (line_end) begin
						res = '{ffrp_pkg::KIND_END, ffrp_pkg::CH_NUL, 1'b1, 1'b1};
						after = ffrp_pkg::MODE_SEEK;
					end else if (blank) begin
						parse_step = 1'b0;
					end else begin
						res.kind = ffrp_pkg::KIND_QUAL;
					end
				end
			endcase
		end
	endfunction

	task automatic put_byte(input logic [7:0] b);
		byte_req_t r;
		r.data = b;
		r.eoi  = 1'b0;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic put_eoi();
		byte_req_t r;
		r.data = 8'($urandom_range(0, 255));
		r.eoi  = 1'b1;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Any byte that does not end a line.
	function automatic logic [7:0] pick_text();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == ffrp_pkg::CH_LF)
			c = ffrp_pkg::CH_CR;
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return ffrp_pkg::CH_SPACE;
			1: return ffrp_pkg::CH_TAB;
			2: return ffrp_pkg::CH_VT;
			3: return ffrp_pkg::CH_FF;
			default: return ffrp_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_residue(input logic quality);
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) begin
			if (quality)
				return 8'($urandom_range(33, 126));
			case ($urandom_range(0, 4))
				0: return "A";
				1: return "C";
				2: return "G";
				3: return "T";
				default: return "N";
			endcase
		end
		if (r < 17)
			return pick_blank();
		return pick_text();
	endfunction

	function automatic logic [7:0] pick_line_end();
		return ($urandom_range(0, 6) == 0) ? ffrp_pkg::CH_NUL : ffrp_pkg::CH_LF;
	endfunction

	// Builds one short record, sometimes cut short by end of input.
	task automatic add_random_record();
		logic [7:0] rec[$];
		logic       fastq;
		logic       close_eoi;
		int         cut;
		close_eoi = 1'b0;
		fastq = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) rec.insert(rec.size(), pick_text());
		rec.insert(rec.size(), fastq ? ffrp_pkg::CH_AT : ffrp_pkg::CH_GT);
		repeat ($urandom_range(0, 8)) rec.insert(rec.size(), pick_text());
		rec.insert(rec.size(), pick_line_end());
		if (fastq) begin
			repeat ($urandom_range(0, 10)) rec.insert(rec.size(), pick_residue(1'b0));
			rec.insert(rec.size(), pick_line_end());
			rec.insert(rec.size(), "+");
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) rec.insert(rec.size(), pick_text());
			rec.insert(rec.size(), pick_line_end());
			repeat ($urandom_range(0, 10)) rec.insert(rec.size(), pick_residue(1'b1));
			case ($urandom_range(0, 5))
				0: close_eoi = 1'b1;
				1: rec.insert(rec.size(), ffrp_pkg::CH_NUL);
				default: rec.insert(rec.size(), ffrp_pkg::CH_LF);
			endcase
		end else begin
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 12)) rec.insert(rec.size(), pick_residue(1'b0));
				rec.insert(rec.size(), ffrp_pkg::CH_LF);
			end
			case ($urandom_range(0, 3))
				0: close_eoi = 1'b1;
				1: rec.insert(rec.size(), ffrp_pkg::CH_NUL);
				default: ;
			endcase
		end
		cut = rec.size();
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, rec.size() - 1);
			close_eoi = 1'b1;
		end
		for (int i = 0; i < cut; i++)
			put_byte(rec[i]);
		if (close_eoi)
			put_eoi();
	endtask

	// Stimulus, then the wait for the last results and the verdict.
	initial begin
		// Directed part: each line type, dropped CR and blank characters, and endings by '>', NUL and end of input.
		put_eoi();
		put_byte(8'hFF);
		put_byte(ffrp_pkg::CH_GT);
		put_byte("N");
		put_byte(ffrp_pkg::CH_CR);
		put_byte(ffrp_pkg::CH_LF);
		put_byte("A");
		put_byte(ffrp_pkg::CH_SPACE);
		put_byte(ffrp_pkg::CH_LF);
		put_byte(ffrp_pkg::CH_GT);
		put_byte(ffrp_pkg::CH_NUL);
		put_byte(8'hFF);
		put_byte(ffrp_pkg::CH_NUL);
		put_byte(ffrp_pkg::CH_AT);
		put_byte("q");
		put_byte(ffrp_pkg::CH_LF);
		put_byte(ffrp_pkg::CH_VT);
		put_byte("G");
		put_byte(ffrp_pkg::CH_LF);
		put_byte("+");
		put_byte(ffrp_pkg::CH_NUL);
		put_byte("I");
		put_byte(ffrp_pkg::CH_FF);
		put_eoi();
		put_byte(ffrp_pkg::CH_GT);
		put_eoi();
		while (pending_reqs.size() < 1230) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 2) == 0)
					put_eoi();
			end else begin
				add_random_record();
			end
		end
		total_items = pending_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (accepted_count == total_items);
		wait (expected_tokens.size() == 0);
		repeat (10) @(posedge clk);
		$display("Parsed %0d input bytes into %0d results: %0d name, %0d sequence, %0d quality.",
			total_items, result_count, kind_seen[ffrp_pkg::KIND_NAME],
			kind_seen[ffrp_pkg::KIND_SEQ], kind_seen[ffrp_pkg::KIND_QUAL]);
		$display("Record ends seen: %0d complete, %0d truncated by end of input.",
			kind_seen[ffrp_pkg::KIND_END] - truncated_ends, truncated_ends);
		if (error_count == 0)
			$display("[fasta_fastq_record_parser_core] OK");
		else
			$display("[fasta_fastq_record_parser_core] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[fasta_fastq_record_parser_core] ERROR");
		$finish;
	end

	// The output side is held off for a long stretch so that the parser backs up.
	initial begin
		wait (accepted_count >= 400);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (300) @(posedge clk);
		long_hold = 1'b0;
	end

	// Driver: a new request is presented only once the previous one has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_idle > 0) begin
				send_idle--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 150 && !long_hold &&
					(pending_reqs.size() / 160) % 4 != 1 && $urandom_range(0, 9) == 0) begin
				send_idle = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else begin
				next_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				byte_value <= next_req.data;
				end_of_input <= next_req.eoi;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold) begin
			out_ready <= 1'b0;
		end else if (recv_idle > 0) begin
			recv_idle--;
			out_ready <= 1'b0;
		end else if (accepted_count < total_items - 150 && (result_count / 120) % 4 != 2 &&
				$urandom_range(0, 7) == 0) begin
			recv_idle = $urandom_range(1, 18) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: checks each output request against the oldest prediction, then
	// predicts from the input request taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_tokens.size() == 0) begin
					$error("unexpected output request: kind %0d char %02h ok %0d fastq %0d",
						out_kind, out_char, record_ok, record_is_fastq);
					error_count++;
				end else begin
					wanted = expected_tokens.pop_front();
					kind_seen[wanted.kind]++;
					if (wanted.kind == ffrp_pkg::KIND_END && !wanted.ok)
						truncated_ends++;
					if (out_kind !== wanted.kind) begin
						$error("out_kind: expected %0d, got %0d", wanted.kind, out_kind);
						error_count++;
					end
					if (out_char !== wanted.ch) begin
						$error("out_char: expected %02h, got %02h", wanted.ch, out_char);
						error_count++;
					end
					if (record_ok !== wanted.ok) begin
						$error("record_ok: expected %0d, got %0d", wanted.ok, record_ok);
						error_count++;
					end
					if (record_is_fastq !== wanted.fastq) begin
						$error("record_is_fastq: expected %0d, got %0d", wanted.fastq,
							record_is_fastq);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				accepted_count++;
				if (parse_step(byte_value, end_of_input, parser_mode, next_mode, predicted))
					expected_tokens.insert(expected_tokens.size(), predicted);
				parser_mode = next_mode;
			end
		end
	end

endmodule
